// ===== rtl/core/servo_bus_read_transaction_macros.svh =====
// Assertion shorthands used by the checker of this block.
`ifndef SERVO_BUS_READ_TRANSACTION_MACROS_SVH
`define SERVO_BUS_READ_TRANSACTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBRT_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("servo bus read: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBRT_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("servo bus read: next-cycle check failed");

`endif

// ===== rtl/core/sbrt_pkg.sv =====
package sbrt_pkg;

  localparam int unsigned SBRT_MAX_READ_BYTES = 8;
  localparam logic [15:0] SBRT_TIMEOUT_RESET  = 16'd12;

  localparam logic [7:0] SBRT_HDR       = 8'hFF;
  localparam logic [7:0] SBRT_INST_READ = 8'h02;
  localparam logic [7:0] SBRT_REQ_LEN   = 8'd4;

  // Input commands
  localparam logic [1:0] SBRT_CMD_START = 2'd0;
  localparam logic [1:0] SBRT_CMD_BYTE  = 2'd1;
  localparam logic [1:0] SBRT_CMD_TICK  = 2'd2;

  // Result kinds
  localparam logic SBRT_KIND_TX     = 1'b0;
  localparam logic SBRT_KIND_REPORT = 1'b1;

  // Finish status codes
  localparam logic [2:0] SBRT_ST_OK       = 3'd0;
  localparam logic [2:0] SBRT_ST_BAD_LEN  = 3'd1;
  localparam logic [2:0] SBRT_ST_CHECKSUM = 3'd2;
  localparam logic [2:0] SBRT_ST_MISMATCH = 3'd3;
  localparam logic [2:0] SBRT_ST_TIMEOUT  = 3'd4;

  // What one accepted word asks of the output stage
  typedef struct packed {
    logic        start;
    logic        report;
    logic [2:0]  status;
    logic [63:0] data;
    logic [3:0]  count;
  } sbrt_evt_t;

endpackage

// ===== rtl/core/sbrt_cmd_if.sv =====
interface sbrt_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] servo_id;
  logic [7:0] reg_addr;
  logic [3:0] read_len;
  logic [7:0] rx_byte;

  modport source (output valid, command, servo_id, reg_addr, read_len, rx_byte,
                  input ready);
  modport sink (input valid, command, servo_id, reg_addr, read_len, rx_byte,
                output ready);
endinterface

// ===== rtl/core/sbrt_res_if.sv =====
interface sbrt_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [2:0]  status;
  logic [63:0] read_data;
  logic [3:0]  read_count;

  modport source (output valid, kind, tx_byte, last, status, read_data, read_count,
                  input ready);
  modport sink (input valid, kind, tx_byte, last, status, read_data, read_count,
                output ready);
endinterface

// ===== rtl/core/servo_bus_read_transaction.sv =====
// Master side of a half-duplex servo bus read.
// cmd_i (valid/ready) takes one word per cycle while ready is high: a start
// (servo id, register address, byte count), a byte received from the bus, or
// a millisecond tick. res_o (valid/ready) gives result words: the eight
// request bytes FF FF id 04 02 addr len chk with last on the checksum byte,
// or one finish report with last set, a status and, when ok, the packed
// parameter bytes. The timeout in milliseconds is written through
// cfg_we_i/cfg_wdata_i. Write it only while the block is idle; the block
// itself does not enforce this. The first result word of an accepted word
// is valid on the next cycle. A word that yields no result (header hunt,
// parameter byte, tick before the timeout, a byte or tick while idle)
// leaves the output register empty. A start holds cmd_i while the request
// drains one byte per cycle as the receiver takes it; a report holds it
// until it is taken. The single output register sets this: cmd_i.ready is
// high when that register is empty or its last word is being taken in the
// same cycle. When the receiver stalls, res_o holds its word and cmd_i.ready
// drops. Reset returns the block to idle with nothing pending and timeout 12.
module servo_bus_read_transaction
  import sbrt_pkg::*;
#(
  parameter int unsigned MaxReadBytes = SBRT_MAX_READ_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  sbrt_cmd_if.sink    cmd_i,
  sbrt_res_if.source  res_o
);

  logic [15:0] timeout_q;
  sbrt_evt_t   evt;
  logic        in_fire;
  logic        out_fire;
  logic        last_beat;

  logic        out_valid_q;
  logic        run_q;
  logic [2:0]  beat_q;
  logic [7:0]  id_q;
  logic [7:0]  addr_q;
  logic [3:0]  len_q;
  logic [7:0]  chk_q;
  logic [2:0]  status_q;
  logic [63:0] data_q;
  logic [3:0]  count_q;
  logic [7:0]  chk_d;
  logic [7:0]  tx_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= SBRT_TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  assign last_beat   = run_q ? (beat_q == 3'd7) : 1'b1;
  assign out_fire    = out_valid_q && res_o.ready;
  assign cmd_i.ready = !out_valid_q || (res_o.ready && last_beat);
  assign in_fire     = cmd_i.valid && cmd_i.ready;

  sbrt_parser #(
    .MaxReadBytes(MaxReadBytes)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_fire),
    .command_i   (cmd_i.command),
    .servo_id_i  (cmd_i.servo_id),
    .read_len_i  (cmd_i.read_len),
    .rx_byte_i   (cmd_i.rx_byte),
    .timeout_ms_i(timeout_q),
    .evt_o       (evt)
  );

  assign chk_d = ~(cmd_i.servo_id + SBRT_REQ_LEN + SBRT_INST_READ + cmd_i.reg_addr +
                   {4'd0, cmd_i.read_len});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      run_q       <= 1'b0;
      beat_q      <= '0;
    end else if (in_fire && (evt.start || evt.report)) begin
      out_valid_q <= 1'b1;
      run_q       <= evt.start;
      beat_q      <= '0;
    end else if (out_fire) begin
      // advance through the request, drop the slot after its last word
      if (last_beat) begin
        out_valid_q <= 1'b0;
      end else begin
        beat_q <= beat_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (evt.start) begin
        id_q   <= cmd_i.servo_id;
        addr_q <= cmd_i.reg_addr;
        len_q  <= cmd_i.read_len;
        chk_q  <= chk_d;
      end
      if (evt.report) begin
        status_q <= evt.status;
        data_q   <= evt.data;
        count_q  <= evt.count;
      end
    end
  end

  always_comb begin
    case (beat_q)
      3'd0, 3'd1: tx_byte = SBRT_HDR;
      3'd2:       tx_byte = id_q;
      3'd3:       tx_byte = SBRT_REQ_LEN;
      3'd4:       tx_byte = SBRT_INST_READ;
      3'd5:       tx_byte = addr_q;
      3'd6:       tx_byte = {4'd0, len_q};
      default:    tx_byte = chk_q;
    endcase
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.kind       = run_q ? SBRT_KIND_TX : SBRT_KIND_REPORT;
  assign res_o.tx_byte    = run_q ? tx_byte : 8'd0;
  assign res_o.last       = last_beat;
  assign res_o.status     = run_q ? SBRT_ST_OK : status_q;
  assign res_o.read_data  = run_q ? 64'd0 : data_q;
  assign res_o.read_count = run_q ? 4'd0 : count_q;

endmodule

// ===== rtl/core/sbrt_parser.sv =====
module sbrt_parser
  import sbrt_pkg::*;
#(
  parameter int unsigned MaxReadBytes = SBRT_MAX_READ_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [1:0]  command_i,
  input  logic [7:0]  servo_id_i,
  input  logic [3:0]  read_len_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] timeout_ms_i,
  output sbrt_evt_t   evt_o
);

  localparam logic [2:0] PH_HDR1  = 3'd0;
  localparam logic [2:0] PH_HDR2  = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;
  localparam logic [2:0] PH_PARAM = 3'd5;

  localparam logic [7:0] MaxLen = 8'(MaxReadBytes + 2);

  logic        busy_q, busy_d;
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  want_id_q, want_id_d;
  logic [3:0]  want_len_q, want_len_d;
  logic [7:0]  got_id_q, got_id_d;
  logic [7:0]  got_len_q, got_len_d;
  logic [7:0]  got_err_q, got_err_d;
  logic [3:0]  pcount_q, pcount_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [7:0]  param_q [MaxReadBytes];
  logic        param_we;
  logic [15:0] elapsed_inc;
  logic [63:0] packed_data;
  sbrt_evt_t   evt;

  always_comb begin
    packed_data = '0;
    for (int i = 0; i < MaxReadBytes; i++) begin
      if (4'(i) < want_len_q) begin
        packed_data[8*i +: 8] = param_q[i];
      end
    end
  end

  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

  always_comb begin
    busy_d     = busy_q;
    phase_d    = phase_q;
    want_id_d  = want_id_q;
    want_len_d = want_len_q;
    got_id_d   = got_id_q;
    got_len_d  = got_len_q;
    got_err_d  = got_err_q;
    pcount_d   = pcount_q;
    sum_d      = sum_q;
    elapsed_d  = elapsed_q;
    param_we   = 1'b0;
    evt        = '0;

    case (command_i)
      SBRT_CMD_START: begin
        evt.start  = 1'b1;
        busy_d     = 1'b1;
        phase_d    = PH_HDR1;
        want_id_d  = servo_id_i;
        want_len_d = read_len_i;
        got_id_d   = '0;
        got_len_d  = '0;
        got_err_d  = '0;
        pcount_d   = '0;
        sum_d      = '0;
        elapsed_d  = '0;
      end
      SBRT_CMD_BYTE: begin
        if (busy_q) begin
          if (elapsed_q >= timeout_ms_i) begin
            evt.report  = 1'b1;
            evt.status  = SBRT_ST_TIMEOUT;
          end else begin
            case (phase_q)
              PH_HDR1: begin
                if (rx_byte_i == SBRT_HDR) phase_d = PH_HDR2;
              end
              PH_HDR2: begin
                phase_d = (rx_byte_i == SBRT_HDR) ? PH_ID : PH_HDR1;
              end
              PH_ID: begin
                got_id_d = rx_byte_i;
                sum_d    = rx_byte_i;
                pcount_d = '0;
                phase_d  = PH_LEN;
              end
              PH_LEN: begin
                got_len_d = rx_byte_i;
                if (rx_byte_i < 8'd2 || rx_byte_i > MaxLen) begin
                  evt.report = 1'b1;
                  evt.status = SBRT_ST_BAD_LEN;
                end else begin
                  sum_d   = sum_q + rx_byte_i;
                  phase_d = PH_ERR;
                end
              end
              PH_ERR: begin
                got_err_d = rx_byte_i;
                sum_d     = sum_q + rx_byte_i;
                phase_d   = PH_PARAM;
              end
              default: begin
                if ({5'd0, pcount_q} + 9'd2 < {1'b0, got_len_q}) begin
                  param_we = ({28'd0, pcount_q} < 32'(MaxReadBytes));
                  pcount_d = pcount_q + 4'd1;
                  sum_d    = sum_q + rx_byte_i;
                end else begin
                  evt.report = 1'b1;
                  if (~sum_q != rx_byte_i) begin
                    evt.status = SBRT_ST_CHECKSUM;
                  end else if (got_id_q != want_id_q || got_err_q != 8'd0 ||
                               {1'b0, got_len_q} != {5'd0, want_len_q} + 9'd2) begin
                    evt.status = SBRT_ST_MISMATCH;
                  end else begin
                    evt.status = SBRT_ST_OK;
                    evt.data   = packed_data;
                    evt.count  = want_len_q;
                  end
                end
              end
            endcase
          end
        end
      end
      SBRT_CMD_TICK: begin
        if (busy_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= timeout_ms_i) begin
            evt.report = 1'b1;
            evt.status = SBRT_ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase

    // A finish report closes the transaction
    if (evt.report) begin
      busy_d  = 1'b0;
      phase_d = PH_HDR1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      phase_q    <= PH_HDR1;
      want_id_q  <= '0;
      want_len_q <= '0;
      got_id_q   <= '0;
      got_len_q  <= '0;
      got_err_q  <= '0;
      pcount_q   <= '0;
      sum_q      <= '0;
      elapsed_q  <= '0;
    end else if (en_i) begin
      busy_q     <= busy_d;
      phase_q    <= phase_d;
      want_id_q  <= want_id_d;
      want_len_q <= want_len_d;
      got_id_q   <= got_id_d;
      got_len_q  <= got_len_d;
      got_err_q  <= got_err_d;
      pcount_q   <= pcount_d;
      sum_q      <= sum_d;
      elapsed_q  <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxReadBytes; i++) begin
      if (en_i && param_we && pcount_q == 4'(i)) begin
        param_q[i] <= rx_byte_i;
      end
    end
  end

  assign evt_o = evt;

endmodule

// ===== rtl/core/sbrt_checker.sv =====
`include "servo_bus_read_transaction_macros.svh"

module sbrt_checker
  import sbrt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_command_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic [7:0]  out_tx_byte_i,
  input logic        out_last_i,
  input logic [2:0]  out_status_i,
  input logic [63:0] out_read_data_i,
  input logic [3:0]  out_read_count_i
);

  // a request run continues until its last byte
  `SBRT_ASSERT_NXT(a_run_continues, clk_i, rst_ni,
    out_valid_i && out_ready_i && out_kind_i == SBRT_KIND_TX && !out_last_i,
    out_valid_i && out_kind_i == SBRT_KIND_TX)

  // hold input while a request is only part sent
  `SBRT_ASSERT_IMP(a_no_take_mid_run, clk_i, rst_ni,
    out_valid_i && out_kind_i == SBRT_KIND_TX && !out_last_i, !in_ready_i)

  `SBRT_ASSERT_IMP(a_report_shape, clk_i, rst_ni,
    out_valid_i && out_kind_i == SBRT_KIND_REPORT, out_last_i && out_tx_byte_i == 8'd0)

  `SBRT_ASSERT_IMP(a_fail_no_data, clk_i, rst_ni,
    out_valid_i && out_kind_i == SBRT_KIND_REPORT && out_status_i != SBRT_ST_OK,
    out_read_data_i == 64'd0 && out_read_count_i == 4'd0)

  `SBRT_ASSERT_NXT(a_start_header, clk_i, rst_ni,
    in_valid_i && in_ready_i && in_command_i == SBRT_CMD_START,
    out_valid_i && out_kind_i == SBRT_KIND_TX && out_tx_byte_i == SBRT_HDR)

endmodule

bind servo_bus_read_transaction sbrt_checker u_sbrt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (cmd_i.valid),
  .in_ready_i      (cmd_i.ready),
  .in_command_i    (cmd_i.command),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .out_kind_i      (res_o.kind),
  .out_tx_byte_i   (res_o.tx_byte),
  .out_last_i      (res_o.last),
  .out_status_i    (res_o.status),
  .out_read_data_i (res_o.read_data),
  .out_read_count_i(res_o.read_count)
);
